### design/ppa_pkg.sv
// particle pool allocator package: sizes, op and status codes, slot record type
// depends on nothing
`timescale 1ns / 1ps
package ppa_pkg;
   localparam int SLOTS = 64;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] OP_SPAWN   = 3'd0;
   localparam logic [2:0] OP_DESTROY = 3'd1;
   localparam logic [2:0] OP_TICK    = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_NOTICK  = 2'd3;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [31:0]        age;
      logic [31:0]        life;
   } slot_rec_type;

   // memory write request
   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   addr;
      slot_rec_type       data;
   } slot_wr_type;
endpackage

### design/particle_pool_allocator.sv
// particle pool allocator top level: sequencer, free stack, active bits
// depends on ppa_pkg, ppa_slot_ram, ppa_integrator
`timescale 1ns / 1ps
// Pool of SLOTS particle slots held in one synchronous record memory, with a
// LIFO free stack in a second small memory whose top entry is cached in a
// register. One command per transfer on req_, one result per command on rsp_,
// and a result register on rsp_ so a waiting result does not hold off the next
// command. Spawn, destroy, clear, a zero tick and bad ops go from S_IDLE straight to
// S_RSP, a read passes through S_READ and S_RDOUT; a tick walks the slots one by one
// through the memory read port and the integrator pipeline in S_TRD, S_TCALC, S_TWB.
// Clear resets the free stack through a low-water mark of the stack pointer:
// entries below the mark were never pushed and hold their reset order. Old
// slot data stays in memory but reads back as zero through per-slot written
// bits cleared with the pool.
module particle_pool_allocator
   import ppa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[2:0], handle[8:3], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
   // life_span, time_step from bit 9 up, zero pad to 272 bits
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], slot[7:2], is_active[8], out_x, out_y, out_z, out_age
   // from bit 9 up, free_slots[143:137], expired[150:144], zero pad to 152
   output logic [151:0] rsp_tdata
);
   typedef enum logic [2:0] {S_IDLE, S_READ, S_RDOUT, S_TRD, S_TCALC, S_TWB, S_RSP}
      state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   handle_ff;
   logic [31:0]        dt_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   top_ff;
   logic [CNT_W-1:0]   low_ff;
   logic [IDX_W-1:0]   head_ff;
   logic               head_load_ff;
   logic [IDX_W-1:0]   stack_mem [SLOTS];
   logic [IDX_W-1:0]   stack_rd_ff;
   logic [CNT_W-1:0]   expired_ff;
   logic [SLOTS-1:0]   active_ff;
   logic [SLOTS-1:0]   written_ff;
   logic [151:0]       rsp_ff;
   logic [151:0]       rsp_in;
   logic [151:0]       rsp_data_ff;
   logic               rsp_valid_ff;

   slot_wr_type        wr;
   logic [IDX_W-1:0]   rd_addr;
   slot_rec_type       rd_data;
   slot_rec_type       rd_q;
   logic [32:0]        age_sum;
   logic [31:0]        age_sat_ff;
   logic signed [31:0] nx, ny, nz;
   logic               push_ok;
   logic               tick_free;
   logic               destroy_push;
   logic               push_en;
   logic [IDX_W-1:0]   push_val;

   ppa_slot_ram u_ram (.clock, .wr, .rd_addr, .rd_data);
   ppa_integrator u_ix (.clock, .pos(rd_data.px), .vel(rd_data.vx), .dt(dt_ff), .result(nx));
   ppa_integrator u_iy (.clock, .pos(rd_data.py), .vel(rd_data.vy), .dt(dt_ff), .result(ny));
   ppa_integrator u_iz (.clock, .pos(rd_data.pz), .vel(rd_data.vz), .dt(dt_ff), .result(nz));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rd_addr    = (state_ff == S_IDLE) ? req_tdata[8:3] : idx_ff;
   assign age_sum    = {1'b0, rd_data.age} + {1'b0, dt_ff};

   always_ff @(posedge clock) begin
      rd_q <= rd_data;
      age_sat_ff <= age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
   end

   assign push_ok = top_ff < CNT_W'(SLOTS);
   assign tick_free = (state_ff == S_TWB) && active_ff[idx_ff] && !(age_sat_ff < rd_q.life);
   assign destroy_push = (state_ff == S_IDLE) && req_tvalid && req_tready &&
                         req_tdata[2:0] == OP_DESTROY && active_ff[req_tdata[8:3]] && push_ok;
   assign push_en  = !reset && (destroy_push || (tick_free && push_ok));
   assign push_val = (state_ff == S_TWB) ? idx_ff : req_tdata[8:3];

   // free stack storage; the entry below the cached top is fetched on a pop
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[IDX_W'(top_ff)] <= push_val;
      end
      stack_rd_ff <= stack_mem[IDX_W'(top_ff - 2'd2)];
   end

   always_comb begin
      wr = '0;
      wr.addr = idx_ff;
      if (state_ff == S_IDLE && req_tvalid && req_tready &&
          req_tdata[2:0] == OP_SPAWN && top_ff != '0) begin
         wr.we = 1'b1;
         wr.addr = head_ff;
         wr.data.px = req_tdata[40:9];
         wr.data.py = req_tdata[72:41];
         wr.data.pz = req_tdata[104:73];
         wr.data.vx = req_tdata[136:105];
         wr.data.vy = req_tdata[168:137];
         wr.data.vz = req_tdata[200:169];
         wr.data.life = req_tdata[232:201];
         wr.data.age = '0;
      end else if (state_ff == S_TWB && active_ff[idx_ff]) begin
         wr.we = 1'b1;
         wr.data = rd_q;
         wr.data.age = age_sat_ff;
         if (age_sat_ff < rd_q.life) begin
            wr.data.px = nx;
            wr.data.py = ny;
            wr.data.pz = nz;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               rsp_in = '0;
               rsp_in[143:137] = top_ff;
               case (req_tdata[2:0])
                  OP_SPAWN: begin
                     if (top_ff == '0) begin
                        rsp_in[1:0] = ST_FULL;
                     end else begin
                        rsp_in[143:137] = top_ff - 1'b1;
                        rsp_in[7:2] = head_ff;
                     end
                  end
                  OP_DESTROY: begin
                     if (!active_ff[req_tdata[8:3]]) begin
                        rsp_in[1:0] = ST_IGNORED;
                     end else if (push_ok) begin
                        rsp_in[143:137] = top_ff + 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (req_tdata[264:233] == '0) rsp_in[1:0] = ST_NOTICK;
                  end
                  OP_READ: ;
                  OP_CLEAR: rsp_in[143:137] = CNT_W'(SLOTS);
                  default: rsp_in[1:0] = ST_IGNORED;
               endcase
            end
         end
         S_RDOUT: begin
            // rd_q now holds the record
            rsp_in[7:2] = handle_ff;
            rsp_in[8] = active_ff[handle_ff];
            if (written_ff[handle_ff]) begin
               rsp_in[40:9] = rd_q.px;
               rsp_in[72:41] = rd_q.py;
               rsp_in[104:73] = rd_q.pz;
               rsp_in[136:105] = rd_q.age;
            end
         end
         S_TWB: begin
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               rsp_in[143:137] = (tick_free && push_ok) ? top_ff + 1'b1 : top_ff;
               rsp_in[150:144] = tick_free ? expired_ff + 1'b1 : expired_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         top_ff <= CNT_W'(SLOTS);
         low_ff <= CNT_W'(SLOTS);
         head_ff <= '0;
         head_load_ff <= 1'b0;
         active_ff <= '0;
         written_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
         if (state_ff == S_RSP && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff <= rsp_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  handle_ff <= req_tdata[8:3];
                  dt_ff <= req_tdata[264:233];
                  idx_ff <= '0;
                  expired_ff <= '0;
                  state_ff <= S_RSP;
                  case (req_tdata[2:0])
                     OP_SPAWN: begin
                        if (top_ff != '0) begin
                           top_ff <= top_ff - 1'b1;
                           if (top_ff - 1'b1 < low_ff) low_ff <= top_ff - 1'b1;
                           active_ff[head_ff] <= 1'b1;
                           written_ff[head_ff] <= 1'b1;
                           // below the low-water mark the stack holds its reset order
                           if (low_ff >= top_ff - 1'b1) begin
                              head_ff <= IDX_W'(SLOTS - 1) - IDX_W'(top_ff - 2'd2);
                           end else begin
                              head_load_ff <= 1'b1;
                           end
                        end
                     end
                     OP_DESTROY: begin
                        if (active_ff[req_tdata[8:3]]) begin
                           active_ff[req_tdata[8:3]] <= 1'b0;
                           if (push_ok) begin
                              top_ff <= top_ff + 1'b1;
                              head_ff <= req_tdata[8:3];
                           end
                        end
                     end
                     OP_TICK: begin
                        if (req_tdata[264:233] != '0) state_ff <= S_TRD;
                     end
                     OP_READ: state_ff <= S_READ;
                     OP_CLEAR: begin
                        top_ff <= CNT_W'(SLOTS);
                        low_ff <= CNT_W'(SLOTS);
                        head_ff <= '0;
                        active_ff <= '0;
                        written_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_READ: state_ff <= S_RDOUT;
            S_RDOUT: state_ff <= S_RSP;
            S_TRD: state_ff <= S_TCALC;
            S_TCALC: state_ff <= S_TWB;
            S_TWB: begin
               if (tick_free) begin
                  active_ff[idx_ff] <= 1'b0;
                  expired_ff <= expired_ff + 1'b1;
                  if (push_ok) begin
                     top_ff <= top_ff + 1'b1;
                     head_ff <= idx_ff;
                  end
               end
               if (idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_ff <= S_RSP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_TRD;
               end
            end
            S_RSP: begin
               // stack entry fetched at the pop is valid in the first cycle here
               if (head_load_ff) begin
                  head_ff <= stack_rd_ff;
                  head_load_ff <= 1'b0;
               end
               if (!rsp_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### design/ppa_slot_ram.sv
// particle pool slot record memory, one write and one registered read port
// depends on ppa_pkg
`timescale 1ns / 1ps
module ppa_slot_ram
   import ppa_pkg::*;
(
   input  logic               clock,
   input  slot_wr_type        wr,
   input  logic [IDX_W-1:0]   rd_addr,
   output slot_rec_type       rd_data
);
   slot_rec_type mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/ppa_integrator.sv
// one axis step: pos + floor(vel*dt / 2^16), saturated; product and pos are registered
// depends on ppa_pkg
`timescale 1ns / 1ps
module ppa_integrator
   import ppa_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] pos,
   input  logic signed [31:0] vel,
   input  logic [31:0]        dt,
   output logic signed [31:0] result
);
   logic signed [64:0] prod_ff;
   logic signed [31:0] pos_ff;
   logic signed [48:0] q;
   logic signed [49:0] s;

   always_ff @(posedge clock) begin
      prod_ff <= 65'(vel) * $signed({1'b0, dt});
      pos_ff  <= pos;
   end

   // arithmetic shift is floor division
   assign q = prod_ff[64:16];
   assign s = 50'(q) + 50'(pos_ff);

   always_comb begin
      if (s > 50'sd2147483647) begin
         result = 32'sh7FFFFFFF;
      end else if (s < -50'sd2147483648) begin
         result = 32'sh80000000;
      end else begin
         result = s[31:0];
      end
   end
endmodule

### tb/sv/particle_pool_checker.sv
// particle pool checker: watches the command and result streams, predicts each result
// depends on ppa_pkg for sizes, op and status codes
`timescale 1ns / 1ps
module particle_pool_checker
   import ppa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [271:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,
   output int           fail_count,
   output int           pending
);
   // highest field first so status lands in the low bits
   typedef struct packed {
      logic [6:0]  expired;
      logic [6:0]  free_slots;
      logic [31:0] out_age;
      logic [31:0] out_z;
      logic [31:0] out_y;
      logic [31:0] out_x;
      logic        is_active;
      logic [5:0]  slot;
      logic [1:0]  status;
   } pool_result_type;

   logic               live [SLOTS];
   logic signed [31:0] pos [SLOTS][3];
   logic signed [31:0] vel [SLOTS][3];
   logic [31:0]        age [SLOTS];
   logic [31:0]        life [SLOTS];
   logic [5:0]         stack [SLOTS];
   int                 top;
   pool_result_type    want_q[$];

   function automatic logic signed [31:0] step_axis(logic signed [31:0] p,
                                                     logic signed [31:0] v,
                                                     logic [31:0] dt);
      logic signed [63:0] prod;
      logic signed [63:0] sum;
      prod = 64'(v) * $signed({32'd0, dt});
      // arithmetic shift floors toward minus infinity
      sum = 64'(p) + (prod >>> 16);
      if (sum > 64'sd2147483647) return 32'h7fffffff;
      if (sum < -64'sd2147483648) return 32'h80000000;
      return sum[31:0];
   endfunction

   task automatic pool_reset();
      for (int i = 0; i < SLOTS; i++) begin
         live[i] = 0; age[i] = 0; life[i] = 0;
         for (int k = 0; k < 3; k++) begin
            pos[i][k] = 0; vel[i][k] = 0;
         end
         stack[i] = 6'(SLOTS - 1 - i);
      end
      top = SLOTS;
   endtask

   task automatic release_slot(int idx);
      live[idx] = 0;
      if (top < SLOTS) begin
         stack[top] = 6'(idx);
         top++;
      end
   endtask

   task automatic predict_result(logic [271:0] d);
      pool_result_type r;
      logic [2:0]  op;
      logic [5:0]  h;
      logic [31:0] dt;
      logic [32:0] a;
      int          idx;
      r = '0;
      op = d[2:0];
      h = d[8:3];
      dt = d[9+7*32 +: 32];
      case (op)
         OP_SPAWN: begin
            if (top == 0) r.status = ST_FULL;
            else begin
               top--;
               idx = stack[top];
               for (int k = 0; k < 3; k++) begin
                  pos[idx][k] = d[9+k*32 +: 32];
                  vel[idx][k] = d[9+(k+3)*32 +: 32];
               end
               life[idx] = d[9+6*32 +: 32];
               age[idx] = 0;
               live[idx] = 1;
               r.slot = 6'(idx);
            end
         end
         OP_DESTROY: begin
            if (!live[h]) r.status = ST_IGNORED;
            else release_slot(h);
         end
         OP_TICK: begin
            if (dt == 0) r.status = ST_NOTICK;
            else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (live[i]) begin
                     a = {1'b0, age[i]} + dt;
                     age[i] = a[32] ? 32'hffffffff : a[31:0];
                     if (age[i] >= life[i]) begin
                        release_slot(i);
                        r.expired++;
                     end else begin
                        for (int k = 0; k < 3; k++)
                           pos[i][k] = step_axis(pos[i][k], vel[i][k], dt);
                     end
                  end
               end
            end
         end
         OP_READ: begin
            r.slot = h;
            r.is_active = live[h];
            r.out_x = pos[h][0];
            r.out_y = pos[h][1];
            r.out_z = pos[h][2];
            r.out_age = age[h];
         end
         OP_CLEAR: pool_reset();
         default: r.status = ST_IGNORED;
      endcase
      r.free_slots = 7'(top);
      want_q.push_back(r);
   endtask

   always @(posedge clock) begin
      pool_result_type got;
      pool_result_type want;
      if (reset) begin
         fail_count = 0;
         pool_reset();
         want_q.delete();
      end else begin
         if (req_tvalid && req_tready) predict_result(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[150:0];
            if (want_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = want_q.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected st=%0d slot=%0d act=%0d x=%h y=%h z=%h",
                        want.status, want.slot, want.is_active, want.out_x, want.out_y,
                        want.out_z, " age=%h free=%0d exp=%0d",
                        want.out_age, want.free_slots, want.expired);
                     $display("          actual   st=%0d slot=%0d act=%0d x=%h y=%h z=%h",
                        got.status, got.slot, got.is_active, got.out_x, got.out_y,
                        got.out_z, " age=%h free=%0d exp=%0d",
                        got.out_age, got.free_slots, got.expired);
                  end
               end
            end
         end
      end
      pending = want_q.size();
   end
endmodule

### tb/sv/particle_pool_allocator_test.sv
// particle pool allocator testbench top: clock, reset, command stimulus, verdict
// depends on ppa_pkg, particle_pool_allocator, particle_pool_checker
`timescale 1ns / 1ps
module particle_pool_allocator_test;
   import ppa_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [271:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [151:0] rsp_tdata;
   int           fail_count;
   int           pending;
   bit           hold_rsp = 0;
   int           rsp_gap = 0;

   particle_pool_allocator dut (.*);
   particle_pool_checker watch (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #200ms;
      $display("TEST FAILED");
      $finish;
   end

   // receiver draws a random wait after each transfer, plus a long hold-off
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) rsp_gap = $urandom_range(0, 7);
      else if (rsp_gap > 0) rsp_gap--;
      rsp_tready <= !hold_rsp && (rsp_gap == 0);
   end

   function automatic logic [31:0] edgy32();
      case ($urandom_range(0, 5))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'hffffffff;
         3: return 32'h0;
         4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_cmd(logic [2:0] op, logic [5:0] h, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz, logic [31:0] ls, logic [31:0] dt, int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, dt, ls, vz, vy, vx, pz, py, px, h, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic rand_cmd(int gap);
      logic [2:0]  op;
      logic [31:0] ls;
      logic [31:0] dt;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_SPAWN;
      else if (pick < 60) op = OP_DESTROY;
      else if (pick < 72) op = OP_TICK;
      else if (pick < 94) op = OP_READ;
      else if (pick < 96) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      ls = ($urandom_range(0, 9) == 0) ? edgy32() : $urandom_range(0, 32'h80000);
      dt = ($urandom_range(0, 9) == 0) ? edgy32() : $urandom_range(0, 32'h20000);
      send_cmd(op, 6'($urandom), edgy32(), edgy32(), edgy32(), edgy32(), edgy32(),
               edgy32(), ls, dt, gap);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, every op, special cases
      send_cmd(OP_READ, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_SPAWN, 6'd0, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000,
               32'hffffffff, 32'hffffffff, 0, 0);
      send_cmd(OP_SPAWN, 6'd0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h80000000,
               32'h7fffffff, 1, 0, 0, 0);
      send_cmd(OP_TICK, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_TICK, 6'd0, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff, 1);
      send_cmd(OP_READ, 6'd63, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_READ, 6'd62, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_DESTROY, 6'd63, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_DESTROY, 6'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(3'd5, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(3'd7, 6'h3f, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 65; i++)
         send_cmd(OP_SPAWN, 6'd0, i, -i, 0, 32'h10000, 0, 0, 32'h40000, 0, 0);
      send_cmd(OP_TICK, 6'd0, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 0);
      send_cmd(OP_READ, 6'd10, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_CLEAR, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_READ, 6'd10, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      drain();
      // long receiver hold-off while the sender keeps going
      fork
         begin
            hold_rsp <= 1;
            repeat (300) @(posedge clock);
            hold_rsp <= 0;
         end
         for (int n = 0; n < 40; n++) rand_cmd(0);
      join
      drain();
      for (int n = 0; n < 1430; n++) begin
         rand_cmd(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
         if (n == 700) drain();
      end
      drain();
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
